@@ design/rgde_pkg.sv @@
// Shared types, constants and the 5x7 glyph table of the rectangle and glyph draw engine.
// No dependencies; the core and the clip and count unit refer to it by scoped names.
package rgde_pkg;

  // Request kinds.
  localparam logic [1:0] OP_FILL    = 2'd0;
  localparam logic [1:0] OP_OUTLINE = 2'd1;
  localparam logic [1:0] OP_CHAR    = 2'd2;
  localparam logic [1:0] OP_NONE    = 2'd3;

  // Character cell geometry.
  localparam int unsigned CELL_COLS  = 6;
  localparam int unsigned CELL_ROWS  = 8;
  localparam int unsigned GLYPH_COLS = 5;
  localparam int unsigned GLYPH_ROWS = 7;
  localparam logic [2:0]  COL_LAST   = 3'(CELL_COLS - 1);
  localparam logic [2:0]  ROW_LAST   = 3'(CELL_ROWS - 1);
  localparam logic [2:0]  SIDE_LAST  = 3'd3;

  // Field widths fixed by the interface.
  localparam int unsigned COORD_W = 9;
  localparam int unsigned COUNT_W = 18;
  localparam int unsigned COLOR_W = 16;
  // Internal signed width for raw and clipped geometry.
  localparam int unsigned GEO_W   = 16;
  // Operand width of the pixel count multiplier (covers display sizes up to 2047).
  localparam int unsigned MUL_W   = 12;
  localparam int unsigned OFF_W   = 11;

  typedef logic signed [GEO_W-1:0] geo_t;
  typedef logic [GLYPH_COLS-1:0][GLYPH_ROWS-1:0] glyph_t;

  // Raw window handed to the clip and count unit.
  typedef struct packed {
    geo_t               x;
    geo_t               y;
    geo_t               w;
    geo_t               h;
    logic [COLOR_W-1:0] color;
  } win_req_t;

  // Clipped window from the clip and count unit.
  typedef struct packed {
    logic               nonempty;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y1;
    logic [COLOR_W-1:0] color;
    logic [COUNT_W-1:0] count;
  } win_res_t;

  // One result transaction as held in the pending and output registers.
  typedef struct packed {
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y1;
    logic [COLOR_W-1:0] color;
    logic [COUNT_W-1:0] count;
    logic               last;
  } out_t;

  function automatic glyph_t mk(input logic [6:0] c0, input logic [6:0] c1,
                                input logic [6:0] c2, input logic [6:0] c3,
                                input logic [6:0] c4);
    return {c4, c3, c2, c1, c0};
  endfunction

  // Glyph columns for a character byte; lower case folds to upper case,
  // unknown bytes give a blank glyph.
  function automatic glyph_t glyph_lookup(input logic [7:0] ch);
    logic [7:0] c;
    glyph_t     g;
    c = ch;
    if (c >= "a" && c <= "z") c = c - 8'd32;
    unique case (c)
      "0": g = mk(7'h3e, 7'h51, 7'h49, 7'h45, 7'h3e);
      "1": g = mk(7'h00, 7'h42, 7'h7f, 7'h40, 7'h00);
      "2": g = mk(7'h42, 7'h61, 7'h51, 7'h49, 7'h46);
      "3": g = mk(7'h21, 7'h41, 7'h45, 7'h4b, 7'h31);
      "4": g = mk(7'h18, 7'h14, 7'h12, 7'h7f, 7'h10);
      "5": g = mk(7'h27, 7'h45, 7'h45, 7'h45, 7'h39);
      "6": g = mk(7'h3c, 7'h4a, 7'h49, 7'h49, 7'h30);
      "7": g = mk(7'h01, 7'h71, 7'h09, 7'h05, 7'h03);
      "8": g = mk(7'h36, 7'h49, 7'h49, 7'h49, 7'h36);
      "9": g = mk(7'h06, 7'h49, 7'h49, 7'h29, 7'h1e);
      "A": g = mk(7'h7e, 7'h11, 7'h11, 7'h11, 7'h7e);
      "B": g = mk(7'h7f, 7'h49, 7'h49, 7'h49, 7'h36);
      "C": g = mk(7'h3e, 7'h41, 7'h41, 7'h41, 7'h22);
      "D": g = mk(7'h7f, 7'h41, 7'h41, 7'h22, 7'h1c);
      "E": g = mk(7'h7f, 7'h49, 7'h49, 7'h49, 7'h41);
      "F": g = mk(7'h7f, 7'h09, 7'h09, 7'h09, 7'h01);
      "G": g = mk(7'h3e, 7'h41, 7'h49, 7'h49, 7'h7a);
      "H": g = mk(7'h7f, 7'h08, 7'h08, 7'h08, 7'h7f);
      "I": g = mk(7'h00, 7'h41, 7'h7f, 7'h41, 7'h00);
      "J": g = mk(7'h20, 7'h40, 7'h41, 7'h3f, 7'h01);
      "K": g = mk(7'h7f, 7'h08, 7'h14, 7'h22, 7'h41);
      "L": g = mk(7'h7f, 7'h40, 7'h40, 7'h40, 7'h40);
      "M": g = mk(7'h7f, 7'h02, 7'h0c, 7'h02, 7'h7f);
      "N": g = mk(7'h7f, 7'h04, 7'h08, 7'h10, 7'h7f);
      "O": g = mk(7'h3e, 7'h41, 7'h41, 7'h41, 7'h3e);
      "P": g = mk(7'h7f, 7'h09, 7'h09, 7'h09, 7'h06);
      "Q": g = mk(7'h3e, 7'h41, 7'h51, 7'h21, 7'h5e);
      "R": g = mk(7'h7f, 7'h09, 7'h19, 7'h29, 7'h46);
      "S": g = mk(7'h46, 7'h49, 7'h49, 7'h49, 7'h31);
      "T": g = mk(7'h01, 7'h01, 7'h7f, 7'h01, 7'h01);
      "U": g = mk(7'h3f, 7'h40, 7'h40, 7'h40, 7'h3f);
      "V": g = mk(7'h1f, 7'h20, 7'h40, 7'h20, 7'h1f);
      "W": g = mk(7'h7f, 7'h20, 7'h18, 7'h20, 7'h7f);
      "X": g = mk(7'h63, 7'h14, 7'h08, 7'h14, 7'h63);
      "Y": g = mk(7'h07, 7'h08, 7'h70, 7'h08, 7'h07);
      "Z": g = mk(7'h61, 7'h51, 7'h49, 7'h45, 7'h43);
      "-": g = mk(7'h08, 7'h08, 7'h08, 7'h08, 7'h08);
      "+": g = mk(7'h08, 7'h08, 7'h3e, 7'h08, 7'h08);
      "*": g = mk(7'h14, 7'h08, 7'h3e, 7'h08, 7'h14);
      "^": g = mk(7'h04, 7'h02, 7'h01, 7'h02, 7'h04);
      "/": g = mk(7'h20, 7'h10, 7'h08, 7'h04, 7'h02);
      ":": g = mk(7'h00, 7'h36, 7'h36, 7'h00, 7'h00);
      ".": g = mk(7'h00, 7'h60, 7'h60, 7'h00, 7'h00);
      ",": g = mk(7'h00, 7'h40, 7'h30, 7'h00, 7'h00);
      "=": g = mk(7'h14, 7'h14, 7'h14, 7'h14, 7'h14);
      "%": g = mk(7'h63, 7'h13, 7'h08, 7'h64, 7'h63);
      "(": g = mk(7'h00, 7'h1c, 7'h22, 7'h41, 7'h00);
      ")": g = mk(7'h00, 7'h41, 7'h22, 7'h1c, 7'h00);
      "_": g = mk(7'h40, 7'h40, 7'h40, 7'h40, 7'h40);
      "<": g = mk(7'h08, 7'h14, 7'h22, 7'h41, 7'h00);
      ">": g = mk(7'h00, 7'h41, 7'h22, 7'h14, 7'h08);
      "!": g = mk(7'h00, 7'h00, 7'h5f, 7'h00, 7'h00);
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

@@ design/rgde_req_if.sv @@
// Request channel of the draw engine: valid/ready handshake plus one drawing request.
// Depends on nothing.
interface rgde_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [11:0] x_pos;
  logic signed [11:0] y_pos;
  logic signed [11:0] width;
  logic signed [11:0] height;
  logic [15:0]        color;
  logic [15:0]        bg_color;
  logic [7:0]         char_code;
  logic [7:0]         scale;

  modport source (
    output valid, op, x_pos, y_pos, width, height, color, bg_color, char_code, scale,
    input  ready
  );
  modport sink (
    input  valid, op, x_pos, y_pos, width, height, color, bg_color, char_code, scale,
    output ready
  );
endinterface

@@ design/rgde_win_if.sv @@
// Result channel of the draw engine: valid/ready handshake plus one clipped window.
// Depends on nothing.
interface rgde_win_if;
  logic        valid;
  logic        ready;
  logic [8:0]  win_x0;
  logic [8:0]  win_y0;
  logic [8:0]  win_x1;
  logic [8:0]  win_y1;
  logic [15:0] pixel_color;
  logic [17:0] pixel_count;
  logic        last;

  modport source (
    output valid, win_x0, win_y0, win_x1, win_y1, pixel_color, pixel_count, last,
    input  ready
  );
  modport sink (
    input  valid, win_x0, win_y0, win_x1, win_y1, pixel_color, pixel_count, last,
    output ready
  );
endinterface

@@ design/rect_and_glyph_draw_engine_core.sv @@
// Top level of the rectangle and glyph draw engine: request sequencer, pending and
// output registers. Depends on rgde_pkg, rgde_req_if, rgde_win_if and rgde_win_unit.
//
// One request becomes a list of clipped display windows, each with one color and a
// pixel count; empty windows are dropped and the final window carries last. A fill is
// one window, an outline four (top, bottom, left, right), a character 48 dots walked
// column by column. Every window goes through the one shared clip and count unit
// (clip into a register, then multiply). A request is taken only while the block is
// idle; the last window of one request may still wait in the output register while
// the next request is accepted.
module rect_and_glyph_draw_engine_core #(
  parameter int DISPLAY_WIDTH  = 480,
  parameter int DISPLAY_HEIGHT = 320
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  rgde_req_if.sink          req_i,
  rgde_win_if.source        win_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state_q, state_d;

  // Request held for the whole sequence.
  logic [1:0]         op_q;
  logic signed [11:0] x_q, y_q, w_q, h_q;
  logic [15:0]        fg_q, bg_q;
  logic [7:0]         ch_q, s_q;

  logic [2:0] col_q, col_d, row_q, row_d;
  logic [rgde_pkg::OFF_W-1:0] col_off_q, col_off_d, row_off_q, row_off_d;

  logic           pend_valid_q, pend_valid_d;
  rgde_pkg::out_t pend_q, pend_d;
  logic           out_valid_q, out_valid_d;
  rgde_pkg::out_t out_q, out_d;

  rgde_pkg::win_req_t raw;
  rgde_pkg::win_res_t res;
  rgde_pkg::glyph_t   glyph;
  logic [rgde_pkg::GLYPH_ROWS-1:0] col_bits;
  logic               dot_on;
  logic               final_win;
  logic               out_busy;
  logic               stall;
  logic               req_fire;

  rgde_pkg::geo_t xs, ys, ws, hs, ss;

  assign req_fire    = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign out_busy    = out_valid_q && !win_o.ready;
  assign stall       = res.nonempty && pend_valid_q && out_busy;

  assign xs = rgde_pkg::GEO_W'(x_q);
  assign ys = rgde_pkg::GEO_W'(y_q);
  assign ws = rgde_pkg::GEO_W'(w_q);
  assign hs = rgde_pkg::GEO_W'(h_q);
  assign ss = $signed({{(rgde_pkg::GEO_W-8){1'b0}}, s_q});

  assign glyph = rgde_pkg::glyph_lookup(ch_q);

  always_comb begin
    col_bits = '0;
    if (col_q < 3'(rgde_pkg::GLYPH_COLS)) col_bits = glyph[col_q];
    dot_on = 1'b0;
    if (row_q < 3'(rgde_pkg::GLYPH_ROWS)) dot_on = col_bits[row_q];
  end

  // Raw window for the current step of the sequence.
  always_comb begin
    raw = '{x: xs, y: ys, w: ws, h: hs, color: fg_q};
    unique case (op_q)
      rgde_pkg::OP_FILL: ;
      rgde_pkg::OP_OUTLINE: begin
        unique case (row_q[1:0])
          2'd0: raw.h = rgde_pkg::geo_t'(1);
          2'd1: begin
            raw.y = ys + hs - rgde_pkg::geo_t'(1);
            raw.h = rgde_pkg::geo_t'(1);
          end
          2'd2: raw.w = rgde_pkg::geo_t'(1);
          2'd3: begin
            raw.x = xs + ws - rgde_pkg::geo_t'(1);
            raw.w = rgde_pkg::geo_t'(1);
          end
        endcase
      end
      rgde_pkg::OP_CHAR: begin
        raw.x     = xs + $signed({{(rgde_pkg::GEO_W-rgde_pkg::OFF_W){1'b0}}, col_off_q});
        raw.y     = ys + $signed({{(rgde_pkg::GEO_W-rgde_pkg::OFF_W){1'b0}}, row_off_q});
        raw.w     = ss;
        raw.h     = ss;
        raw.color = dot_on ? fg_q : bg_q;
      end
      rgde_pkg::OP_NONE: ;
    endcase
  end

  always_comb begin
    final_win = 1'b1;
    unique case (op_q)
      rgde_pkg::OP_FILL:    final_win = 1'b1;
      rgde_pkg::OP_OUTLINE: final_win = (row_q == rgde_pkg::SIDE_LAST);
      rgde_pkg::OP_CHAR:    final_win = (col_q == rgde_pkg::COL_LAST) &&
                                        (row_q == rgde_pkg::ROW_LAST);
      rgde_pkg::OP_NONE:    final_win = 1'b1;
    endcase
  end

  rgde_win_unit #(
    .DISPLAY_WIDTH (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT(DISPLAY_HEIGHT)
  ) u_win (
    .clk_i(clk_i),
    .ld_i (state_q == S_CALC),
    .req_i(raw),
    .res_o(res)
  );

  // Sequencer. The newest non-empty window waits in the pending register until the
  // next one shows up or the request ends, which is what decides its last flag.
  always_comb begin
    state_d      = state_q;
    col_d        = col_q;
    row_d        = row_q;
    col_off_d    = col_off_q;
    row_off_d    = row_off_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q && !win_o.ready;
    out_d        = out_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          col_d     = '0;
          row_d     = '0;
          col_off_d = '0;
          row_off_d = '0;
          state_d   = (req_i.op == rgde_pkg::OP_NONE) ? S_FIN : S_CALC;
        end
      end
      S_CALC: state_d = S_MUL;
      S_MUL: begin
        if (!stall) begin
          if (res.nonempty) begin
            if (pend_valid_q) begin
              out_d       = pend_q;
              out_valid_d = 1'b1;
            end
            pend_d.x0    = res.x0;
            pend_d.y0    = res.y0;
            pend_d.x1    = res.x1;
            pend_d.y1    = res.y1;
            pend_d.color = res.color;
            pend_d.count = res.count;
            pend_d.last  = 1'b0;
            pend_valid_d = 1'b1;
          end
          if (final_win) begin
            state_d = S_FIN;
          end else begin
            state_d = S_CALC;
            if (row_q == rgde_pkg::ROW_LAST) begin
              row_d     = '0;
              row_off_d = '0;
              col_d     = col_q + 3'd1;
              col_off_d = col_off_q + rgde_pkg::OFF_W'(s_q);
            end else begin
              row_d     = row_q + 3'd1;
              row_off_d = row_off_q + rgde_pkg::OFF_W'(s_q);
            end
          end
        end
      end
      S_FIN: begin
        if (!pend_valid_q) begin
          state_d = S_IDLE;
        end else if (!out_busy) begin
          out_d        = pend_q;
          out_d.last   = 1'b1;
          out_valid_d  = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= rgde_pkg::OP_NONE;
      col_q        <= '0;
      row_q        <= '0;
      col_off_q    <= '0;
      row_off_q    <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      if (req_fire) op_q <= req_i.op;
      col_q        <= col_d;
      row_q        <= row_d;
      col_off_q    <= col_off_d;
      row_off_q    <= row_off_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
    if (req_fire) begin
      x_q  <= req_i.x_pos;
      y_q  <= req_i.y_pos;
      w_q  <= req_i.width;
      h_q  <= req_i.height;
      fg_q <= req_i.color;
      bg_q <= req_i.bg_color;
      ch_q <= req_i.char_code;
      s_q  <= req_i.scale;
    end
  end

  assign win_o.valid       = out_valid_q;
  assign win_o.win_x0      = out_q.x0;
  assign win_o.win_y0      = out_q.y0;
  assign win_o.win_x1      = out_q.x1;
  assign win_o.win_y1      = out_q.y1;
  assign win_o.pixel_color = out_q.color;
  assign win_o.pixel_count = out_q.count;
  assign win_o.last        = out_q.last;

`ifndef ASSERT_OFF
  // Nothing may be left pending once the sequencer has gone idle.
  a_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_valid_q)
    else $error("pending window left behind in idle");

  // The column walk never passes the last cell column.
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (col_q <= rgde_pkg::COL_LAST))
    else $error("cell column out of range");

  // A blocked handoff keeps the sequence where it is.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL && stall) |=>
      (state_q == S_MUL && $stable(col_q) && $stable(row_q)))
    else $error("sequence advanced while the window handoff was blocked");
`endif

endmodule

@@ design/rgde_win_unit.sv @@
// Shared clip and pixel count unit: clips one raw window to the display, registers it,
// and forms the window corners and pixel count. Depends on rgde_pkg.
module rgde_win_unit #(
  parameter int DISPLAY_WIDTH  = 480,
  parameter int DISPLAY_HEIGHT = 320
) (
  input  logic                clk_i,
  input  logic                ld_i,
  input  rgde_pkg::win_req_t  req_i,
  output rgde_pkg::win_res_t  res_o
);

  localparam rgde_pkg::geo_t LimX = rgde_pkg::GEO_W'(DISPLAY_WIDTH);
  localparam rgde_pkg::geo_t LimY = rgde_pkg::GEO_W'(DISPLAY_HEIGHT);

  // Returns {clipped position, clipped length}.
  function automatic logic [2*rgde_pkg::GEO_W-1:0] clip_axis(input rgde_pkg::geo_t p,
                                                              input rgde_pkg::geo_t l,
                                                              input rgde_pkg::geo_t lim);
    rgde_pkg::geo_t p1;
    rgde_pkg::geo_t l1;
    p1 = p;
    l1 = l;
    if (p1 < 0) begin
      l1 = l1 + p1;
      p1 = '0;
    end
    if (p1 + l1 > lim) l1 = lim - p1;
    return {p1, l1};
  endfunction

  logic [2*rgde_pkg::GEO_W-1:0] cx_full, cy_full;
  rgde_pkg::geo_t cx_q, cw_q, cy_q, ch_q;
  logic [rgde_pkg::COLOR_W-1:0] color_q;
  rgde_pkg::geo_t xe, ye;
  logic [2*rgde_pkg::MUL_W-1:0] prod;

  assign cx_full = clip_axis(req_i.x, req_i.w, LimX);
  assign cy_full = clip_axis(req_i.y, req_i.h, LimY);

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      cx_q    <= cx_full[2*rgde_pkg::GEO_W-1:rgde_pkg::GEO_W];
      cw_q    <= cx_full[rgde_pkg::GEO_W-1:0];
      cy_q    <= cy_full[2*rgde_pkg::GEO_W-1:rgde_pkg::GEO_W];
      ch_q    <= cy_full[rgde_pkg::GEO_W-1:0];
      color_q <= req_i.color;
    end
  end

  assign xe   = cx_q + cw_q - rgde_pkg::geo_t'(1);
  assign ye   = cy_q + ch_q - rgde_pkg::geo_t'(1);
  // A non-empty window has both lengths within the display, so the low bits suffice.
  assign prod = cw_q[rgde_pkg::MUL_W-1:0] * ch_q[rgde_pkg::MUL_W-1:0];

  always_comb begin
    res_o.nonempty = (cw_q > 0) && (ch_q > 0);
    res_o.x0       = cx_q[rgde_pkg::COORD_W-1:0];
    res_o.y0       = cy_q[rgde_pkg::COORD_W-1:0];
    res_o.x1       = xe[rgde_pkg::COORD_W-1:0];
    res_o.y1       = ye[rgde_pkg::COORD_W-1:0];
    res_o.color    = color_q;
    res_o.count    = prod[rgde_pkg::COUNT_W-1:0];
  end

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for rect_and_glyph_draw_engine_core: a directed table, then random
// requests, checked against table entries or a behavioral predictor. Uses rgde_pkg, rgde_req_if, rgde_win_if.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rgde_pkg::*;

  localparam int SCREEN_W    = 480;
  localparam int SCREEN_H    = 320;
  localparam int RANDOM_REQS = 136;
  localparam int LONG_HOLD   = 400;
  localparam int DRAIN_WAIT  = 250;
  localparam int MAX_REPORTS = 10;

  localparam bit FROM_MODEL = 1'b0;
  localparam bit TYPED      = 1'b1;
  localparam bit NO_WIN     = 1'b0;
  localparam bit ONE_WIN    = 1'b1;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [11:0] x;
    logic signed [11:0] y;
    logic signed [11:0] w;
    logic signed [11:0] h;
    logic [15:0]        fg;
    logic [15:0]        bg;
    logic [7:0]         ch;
    logic [7:0]         scale;
  } draw_req_t;

  typedef struct packed {
    draw_req_t req;
    logic      typed;
    logic      one_win;
    out_t      win;
  } stim_row_t;

  // Five glyph columns per entry, column 0 in the top byte; bit 0 of a column is the top row.
  localparam logic [0:9][39:0] DIGIT_FONT = {
    40'h3e_51_49_45_3e, 40'h00_42_7f_40_00, 40'h42_61_51_49_46, 40'h21_41_45_4b_31,
    40'h18_14_12_7f_10, 40'h27_45_45_45_39, 40'h3c_4a_49_49_30, 40'h01_71_09_05_03,
    40'h36_49_49_49_36, 40'h06_49_49_29_1e
  };
  localparam logic [0:25][39:0] ALPHA_FONT = {
    40'h7e_11_11_11_7e, 40'h7f_49_49_49_36, 40'h3e_41_41_41_22, 40'h7f_41_41_22_1c,
    40'h7f_49_49_49_41, 40'h7f_09_09_09_01, 40'h3e_41_49_49_7a, 40'h7f_08_08_08_7f,
    40'h00_41_7f_41_00, 40'h20_40_41_3f_01, 40'h7f_08_14_22_41, 40'h7f_40_40_40_40,
    40'h7f_02_0c_02_7f, 40'h7f_04_08_10_7f, 40'h3e_41_41_41_3e, 40'h7f_09_09_09_06,
    40'h3e_41_51_21_5e, 40'h7f_09_19_29_46, 40'h46_49_49_49_31, 40'h01_01_7f_01_01,
    40'h3f_40_40_40_3f, 40'h1f_20_40_20_1f, 40'h7f_20_18_20_7f, 40'h63_14_08_14_63,
    40'h07_08_70_08_07, 40'h61_51_49_45_43
  };
  localparam logic [0:15][7:0] PUNCT_CHARS = "-+*^/:.,=%()_<>!";
  localparam logic [0:15][39:0] PUNCT_FONT = {
    40'h08_08_08_08_08, 40'h08_08_3e_08_08, 40'h14_08_3e_08_14, 40'h04_02_01_02_04,
    40'h20_10_08_04_02, 40'h00_36_36_00_00, 40'h00_60_60_00_00, 40'h00_40_30_00_00,
    40'h14_14_14_14_14, 40'h63_13_08_64_63, 40'h00_1c_22_41_00, 40'h00_41_22_1c_00,
    40'h40_40_40_40_40, 40'h08_14_22_41_00, 40'h00_41_22_14_08, 40'h00_00_5f_00_00
  };

  localparam stim_row_t DIRECTED [24] = '{
    '{'{OP_FILL, 12'sd10, 12'sd20, 12'sd30, 12'sd40, 16'hF800, 16'h0000, 8'h00, 8'd1},
      TYPED, ONE_WIN, '{9'd10, 9'd20, 9'd39, 9'd59, 16'hF800, 18'd1200, 1'b1}},
    '{'{OP_FILL, 12'sd0, 12'sd0, 12'sd480, 12'sd320, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF},
      TYPED, ONE_WIN, '{9'd0, 9'd0, 9'd479, 9'd319, 16'hFFFF, 18'd153600, 1'b1}},
    '{'{OP_FILL, -12'sd2048, -12'sd2048, 12'sd2047, 12'sd2047, 16'h1234, 16'h0, 8'h0, 8'd0},
      TYPED, NO_WIN, '0},
    '{'{OP_FILL, 12'sd2047, 12'sd0, 12'sd10, 12'sd10, 16'h1234, 16'h0, 8'h0, 8'd0},
      TYPED, NO_WIN, '0},
    '{'{OP_FILL, -12'sd5, -12'sd7, 12'sd2047, 12'sd2047, 16'h07E0, 16'h0, 8'h0, 8'd0},
      TYPED, ONE_WIN, '{9'd0, 9'd0, 9'd479, 9'd319, 16'h07E0, 18'd153600, 1'b1}},
    '{'{OP_FILL, 12'sd5, 12'sd5, 12'sd0, 12'sd10, 16'h001F, 16'h0, 8'h0, 8'd0},
      TYPED, NO_WIN, '0},
    '{'{OP_FILL, 12'sd5, 12'sd5, -12'sd2048, -12'sd2048, 16'h001F, 16'h0, 8'h0, 8'd0},
      TYPED, NO_WIN, '0},
    '{'{OP_FILL, 12'sd479, 12'sd319, 12'sd1, 12'sd1, 16'hA5A5, 16'h0, 8'h0, 8'd0},
      TYPED, ONE_WIN, '{9'd479, 9'd319, 9'd479, 9'd319, 16'hA5A5, 18'd1, 1'b1}},
    '{'{OP_OUTLINE, 12'sd10, 12'sd10, 12'sd20, 12'sd5, 16'h5A5A, 16'h0, 8'h0, 8'd0},
      FROM_MODEL, NO_WIN, '0},
    '{'{OP_OUTLINE, 12'sd0, 12'sd0, 12'sd1, 12'sd1, 16'hFFFF, 16'h0, 8'h0, 8'd0},
      FROM_MODEL, NO_WIN, '0},
    '{'{OP_OUTLINE, -12'sd3, 12'sd100, 12'sd10, 12'sd10, 16'h0F0F, 16'h0, 8'h0, 8'd0},
      FROM_MODEL, NO_WIN, '0},
    '{'{OP_OUTLINE, -12'sd2048, -12'sd2048, 12'sd2047, 12'sd2047, 16'hF00F, 16'h0, 8'h0, 8'd0},
      FROM_MODEL, NO_WIN, '0},
    '{'{OP_CHAR, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 16'hFFFF, 16'h0000, "A", 8'd1},
      FROM_MODEL, NO_WIN, '0},
    '{'{OP_CHAR, 12'sd40, 12'sd40, 12'sd0, 12'sd0, 16'h07E0, 16'h0821, "a", 8'd2},
      FROM_MODEL, NO_WIN, '0},
    '{'{OP_CHAR, 12'sd100, 12'sd50, 12'sd0, 12'sd0, 16'hF81F, 16'h0000, "0", 8'd3},
      FROM_MODEL, NO_WIN, '0},
    '{'{OP_CHAR, 12'sd200, 12'sd10, 12'sd0, 12'sd0, 16'hFFE0, 16'h001F, "!", 8'd1},
      FROM_MODEL, NO_WIN, '0},
    '{'{OP_CHAR, 12'sd300, 12'sd10, 12'sd0, 12'sd0, 16'hFFFF, 16'h1111, 8'hFF, 8'd1},
      FROM_MODEL, NO_WIN, '0},
    '{'{OP_CHAR, 12'sd310, 12'sd10, 12'sd0, 12'sd0, 16'hFFFF, 16'h2222, " ", 8'd1},
      FROM_MODEL, NO_WIN, '0},
    '{'{OP_CHAR, 12'sd20, 12'sd20, 12'sd0, 12'sd0, 16'hFFFF, 16'h0000, "Z", 8'd0},
      TYPED, NO_WIN, '0},
    '{'{OP_CHAR, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 16'hABCD, 16'h5432, "%", 8'd255},
      FROM_MODEL, NO_WIN, '0},
    '{'{OP_CHAR, 12'sd476, 12'sd316, 12'sd0, 12'sd0, 16'h8410, 16'h0001, "9", 8'd1},
      FROM_MODEL, NO_WIN, '0},
    '{'{OP_CHAR, -12'sd3, -12'sd3, 12'sd0, 12'sd0, 16'h7BEF, 16'hFFFF, "_", 8'd2},
      FROM_MODEL, NO_WIN, '0},
    '{'{OP_NONE, 12'sd10, 12'sd10, 12'sd10, 12'sd10, 16'hFFFF, 16'hFFFF, "A", 8'd1},
      TYPED, NO_WIN, '0},
    '{'{OP_CHAR, 12'sd2047, 12'sd2047, 12'sd0, 12'sd0, 16'hFFFF, 16'h0, "z", 8'd1},
      FROM_MODEL, NO_WIN, '0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  rgde_req_if req_if ();
  rgde_win_if win_if ();

  rect_and_glyph_draw_engine_core #(
    .DISPLAY_WIDTH (SCREEN_W),
    .DISPLAY_HEIGHT(SCREEN_H)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .win_o (win_if)
  );

  out_t  pending_windows[$];
  int    errors = 0;
  int    windows_seen = 0;
  int    hold_off_asks = 0;
  bit    sender_burst = 1'b0;
  string char_pool =
    "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz-+*^/:.,=%()_<>! ";

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [7:0] glyph_column(logic [7:0] ch, int col);
    logic [7:0]  c;
    logic [39:0] g;
    c = ch;
    g = '0;
    if (c >= "a" && c <= "z") c = c - ("a" - "A");
    if (c >= "0" && c <= "9") begin
      g = DIGIT_FONT[c - "0"];
    end else if (c >= "A" && c <= "Z") begin
      g = ALPHA_FONT[c - "A"];
    end else begin
      for (int k = 0; k < 16; k++) if (PUNCT_CHARS[k] == c) g = PUNCT_FONT[k];
    end
    return (col < 5) ? g[8*(4-col) +: 8] : 8'h00;
  endfunction

  // Clips one window to the screen and queues it unless nothing is left of it.
  function automatic void clip_window(int x, int y, int w, int h, logic [15:0] c);
    out_t win;
    if (x < 0) begin
      w += x;
      x = 0;
    end
    if (y < 0) begin
      h += y;
      y = 0;
    end
    if (x + w > SCREEN_W) w = SCREEN_W - x;
    if (y + h > SCREEN_H) h = SCREEN_H - y;
    if (w <= 0 || h <= 0) return;
    win.x0    = 9'(x);
    win.y0    = 9'(y);
    win.x1    = 9'(x + w - 1);
    win.y1    = 9'(y + h - 1);
    win.color = c;
    win.count = 18'(w * h);
    win.last  = 1'b0;
    pending_windows.push_back(win);
  endfunction

  function automatic void predict_windows(draw_req_t r);
    int         first;
    int         x, y, w, h, s;
    logic [7:0] bits;
    first = pending_windows.size();
    x = $signed(r.x);
    y = $signed(r.y);
    w = $signed(r.w);
    h = $signed(r.h);
    s = r.scale;
    case (r.op)
      OP_FILL: clip_window(x, y, w, h, r.fg);
      OP_OUTLINE: begin
        clip_window(x, y, w, 1, r.fg);
        clip_window(x, y + h - 1, w, 1, r.fg);
        clip_window(x, y, 1, h, r.fg);
        clip_window(x + w - 1, y, 1, h, r.fg);
      end
      OP_CHAR: begin
        for (int col = 0; col < 6; col++) begin
          bits = glyph_column(r.ch, col);
          for (int row = 0; row < 8; row++)
            clip_window(x + col * s, y + row * s, s, s, bits[row] ? r.fg : r.bg);
        end
      end
      default: ;
    endcase
    if (pending_windows.size() > first)
      pending_windows[pending_windows.size() - 1].last = 1'b1;
  endfunction

  function automatic draw_req_t random_request();
    draw_req_t r;
    int        pick;
    pick = $urandom_range(0, 99);
    r.op = (pick < 30) ? OP_FILL : (pick < 60) ? OP_OUTLINE : (pick < 95) ? OP_CHAR : OP_NONE;
    // Mostly near the screen, so that clipping happens on every edge; sometimes anything.
    if ($urandom_range(0, 4) != 0) begin
      r.x = 12'($urandom_range(0, 540) - 30);
      r.y = 12'($urandom_range(0, 380) - 30);
      r.w = 12'($urandom_range(0, 130) - 4);
      r.h = 12'($urandom_range(0, 130) - 4);
    end else begin
      r.x = 12'($urandom);
      r.y = 12'($urandom);
      r.w = 12'($urandom);
      r.h = 12'($urandom);
    end
    r.fg = 16'($urandom);
    r.bg = 16'($urandom);
    pick = $urandom_range(0, 19);
    r.scale = (pick < 15) ? 8'($urandom_range(1, 6)) : (pick < 17) ? 8'd0 : 8'($urandom);
    if ($urandom_range(0, 3) != 0) r.ch = char_pool[$urandom_range(0, char_pool.len() - 1)];
    else r.ch = 8'($urandom);
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the request was taken.
  task automatic send_request(draw_req_t r, bit typed, bit one_win, out_t win);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.op        = r.op;
    req_if.x_pos     = r.x;
    req_if.y_pos     = r.y;
    req_if.width     = r.w;
    req_if.height    = r.h;
    req_if.color     = r.fg;
    req_if.bg_color  = r.bg;
    req_if.char_code = r.ch;
    req_if.scale     = r.scale;
    req_if.valid     = 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    if (!typed) predict_windows(r);
    else if (one_win) pending_windows.push_back(win);
    @(negedge clk_i);
  endtask

  initial begin
    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.op        = OP_FILL;
    req_if.x_pos     = '0;
    req_if.y_pos     = '0;
    req_if.width     = '0;
    req_if.height    = '0;
    req_if.color     = '0;
    req_if.bg_color  = '0;
    req_if.char_code = '0;
    req_if.scale     = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (DIRECTED[i])
      send_request(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].one_win, DIRECTED[i].win);

    for (int i = 0; i < RANDOM_REQS; i++) begin
      // The receiver stops for a long while here, and the sender keeps offering requests.
      if (i == 30) hold_off_asks++;
      sender_burst = (i >= 50 && i < 80);
      if (i == 90) begin
        req_if.valid = 1'b0;
        while (pending_windows.size() != 0) @(negedge clk_i);
      end
      send_request(random_request(), FROM_MODEL, NO_WIN, '0);
    end
    req_if.valid = 1'b0;

    while (pending_windows.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
    if (errors == 0 && pending_windows.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Result side: a random stall before each transaction, no stalls for a stretch of
  // results, and one long hold-off when the sender asks for it.
  initial begin
    int stall;
    int hold_off_done;
    hold_off_done = 0;
    win_if.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_off_asks != hold_off_done) begin
        win_if.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        hold_off_done++;
      end
      stall = (windows_seen >= 200 && windows_seen < 400) ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        win_if.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      win_if.ready = 1'b1;
      do @(posedge clk_i); while (!win_if.valid);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin : check_windows
    out_t got;
    out_t want;
    if (rst_ni && win_if.valid && win_if.ready) begin
      got = '{win_if.win_x0, win_if.win_y0, win_if.win_x1, win_if.win_y1,
              win_if.pixel_color, win_if.pixel_count, win_if.last};
      windows_seen++;
      if (pending_windows.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("%0t: unexpected window", $realtime);
          $display("  actual   x0=%0d y0=%0d x1=%0d y1=%0d color=%h count=%0d last=%b",
                   got.x0, got.y0, got.x1, got.y1, got.color, got.count, got.last);
        end
      end else begin
        want = pending_windows.pop_front();
        if (got.x0 !== want.x0 || got.y0 !== want.y0 || got.x1 !== want.x1 ||
            got.y1 !== want.y1 || got.color !== want.color || got.count !== want.count ||
            got.last !== want.last) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("%0t: window mismatch", $realtime);
            $display("  expected x0=%0d y0=%0d x1=%0d y1=%0d color=%h count=%0d last=%b",
                     want.x0, want.y0, want.x1, want.y1, want.color, want.count, want.last);
            $display("  actual   x0=%0d y0=%0d x1=%0d y1=%0d color=%h count=%0d last=%b",
                     got.x0, got.y0, got.x1, got.y1, got.color, got.count, got.last);
          end
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
